@@ src/stsid_pkg.sv @@
// ----------------------------------------------------------------------------
// stsid_pkg
// Shared types, codes and sizes for the sorted table search/insert/delete
// block.
// ----------------------------------------------------------------------------
package stsid_pkg;

  localparam int DEPTH  = 32;
  localparam int KEY_W  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 6;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entries_now;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic cmp;
    logic shift_init;
    logic shift;
    logic wr_key;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            range_open;
    logic            hit;
    logic            last;
    logic            move_more;
    logic            out_free;
  } stat_t;

endpackage

@@ src/stsid_ram.sv @@
// ----------------------------------------------------------------------------
// stsid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stsid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/stsid_datapath.sv @@
// ----------------------------------------------------------------------------
// stsid_datapath
// Table storage, search bounds, shift pointers and the result register.
// ----------------------------------------------------------------------------
module stsid_datapath
  import stsid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  output stat_t st,
  input  req_t  req,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp
);

  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hie;
  logic [IDX_W-1:0]        at;
  logic                    found;
  logic [CNT_W-1:0]        j;
  logic                    pend;
  logic [IDX_W-1:0]        pend_addr;

  logic [CNT_W:0]          sum;
  logic [IDX_W-1:0]        mid;
  logic signed [KEY_W-1:0] e;
  logic                    less;
  logic [CNT_W-1:0]        lo_next;
  logic [CNT_W-1:0]        hie_next;
  logic [CNT_W-1:0]        j_less;
  logic                    is_ins;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [KEY_W-1:0]        wdata;
  logic [IDX_W-1:0]        raddr;
  logic [KEY_W-1:0]        rdata;

  logic [STAT_W-1:0]       res_status;
  logic [IDX_W-1:0]        res_pos;
  logic [CNT_W-1:0]        cnt_next;

  stsid_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_ins = (op == OP_INSERT);

  // Lower bound probes at floor((lo + hi) / 2); exact search uses hi - 1.
  always_comb begin
    if (is_ins) begin
      sum = {1'b0, lo} + {1'b0, hie};
    end else begin
      sum = {1'b0, lo} + {1'b0, hie} - {{CNT_W{1'b0}}, 1'b1};
    end
    mid      = sum[IDX_W:1];
    e        = $signed(rdata);
    less     = (e < key);
    lo_next  = less ? ({{(CNT_W-IDX_W){1'b0}}, mid} + {{(CNT_W-1){1'b0}}, 1'b1}) : lo;
    hie_next = less ? hie : {{(CNT_W-IDX_W){1'b0}}, mid};
    j_less   = j - {{(CNT_W-1){1'b0}}, 1'b1};
  end

  always_comb begin
    st.op         = op;
    st.full       = (cnt == CNT_W'(DEPTH));
    st.range_open = (lo < hie);
    st.hit        = !is_ins && (e == key);
    st.last       = !(lo_next < hie_next);
    st.move_more  = is_ins ? (j > {{(CNT_W-IDX_W){1'b0}}, at}) : (j < cnt);
    st.out_free   = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    raddr = is_ins ? j_less[IDX_W-1:0] : j[IDX_W-1:0];
    if (cmd.rd_mid) begin
      raddr = mid;
    end
    we    = pend || cmd.wr_key;
    waddr = cmd.wr_key ? at : pend_addr;
    wdata = cmd.wr_key ? key : rdata;
  end

  always_comb begin
    res_status = ST_MISS;
    res_pos    = '0;
    cnt_next   = cnt;
    case (op)
      OP_SEARCH: begin
        if (found) begin
          res_status = ST_OK;
          res_pos    = at;
        end
      end
      OP_INSERT: begin
        if (cnt == CNT_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_pos    = at;
          cnt_next   = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end
      OP_DELETE: begin
        if (found) begin
          res_status = ST_OK;
          res_pos    = at;
          cnt_next   = cnt - {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req.operation;
      key   <= req.value;
      lo    <= '0;
      hie   <= cnt;
      at    <= '0;
      found <= 1'b0;
    end
    if (cmd.cmp) begin
      if (st.hit) begin
        found <= 1'b1;
        at    <= mid;
      end else begin
        lo  <= lo_next;
        hie <= hie_next;
        at  <= lo_next[IDX_W-1:0];
      end
    end
    if (cmd.shift_init) begin
      j <= is_ins ? cnt : ({{(CNT_W-IDX_W){1'b0}}, at} + {{(CNT_W-1){1'b0}}, 1'b1});
    end
    if (cmd.shift && st.move_more) begin
      pend_addr <= is_ins ? j[IDX_W-1:0] : j_less[IDX_W-1:0];
      j         <= is_ins ? j_less : (j + {{(CNT_W-1){1'b0}}, 1'b1});
    end
    if (cmd.finish) begin
      rsp.status      <= res_status;
      rsp.position    <= POS_W'(res_pos);
      rsp.entries_now <= POS_W'(cnt_next);
    end
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pend <= cmd.shift && st.move_more;
      if (cmd.finish) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/stsid_ctrl.sv @@
// ----------------------------------------------------------------------------
// stsid_ctrl
// Sequencer that steps the datapath through probes, shifts and the result.
// ----------------------------------------------------------------------------
module stsid_ctrl
  import stsid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CHECK      = 3'd1;
  localparam logic [2:0] S_PROBE_RD   = 3'd2;
  localparam logic [2:0] S_PROBE_CMP  = 3'd3;
  localparam logic [2:0] S_SHIFT_INIT = 3'd4;
  localparam logic [2:0] S_SHIFT      = 3'd5;
  localparam logic [2:0] S_WRKEY      = 3'd6;
  localparam logic [2:0] S_DONE       = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_ins;

  assign is_ins    = (st.op == OP_INSERT);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((st.op != OP_SEARCH && st.op != OP_INSERT && st.op != OP_DELETE) ||
            (is_ins && st.full)) begin
          state_next = S_DONE;
        end else if (st.range_open) begin
          state_next = S_PROBE_RD;
        end else if (is_ins) begin
          state_next = S_SHIFT_INIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PROBE_RD: begin
        cmd.rd_mid = 1'b1;
        state_next = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        cmd.cmp = 1'b1;
        if (st.hit) begin
          state_next = (st.op == OP_DELETE) ? S_SHIFT_INIT : S_DONE;
        end else if (st.last) begin
          state_next = is_ins ? S_SHIFT_INIT : S_DONE;
        end else begin
          state_next = S_PROBE_RD;
        end
      end
      S_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_next     = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!st.move_more) begin
          state_next = is_ins ? S_WRKEY : S_DONE;
        end
      end
      S_WRKEY: begin
        cmd.wr_key = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/sorted_table_search_insert_delete.sv @@
// ----------------------------------------------------------------------------
// sorted_table_search_insert_delete
// Ascending table of signed keys with binary search, insert and delete.
// ----------------------------------------------------------------------------
// A request beat on req carries an operation and a key; each request yields
// exactly one response beat on rsp with a status, a position and the entry
// count after the operation. Both channels use valid and stall.
// One request is worked on at a time. A search makes P probes of the binary
// search (at most log2(DEPTH) + 1), each a read and a compare on the one
// read port of the table RAM. Insert and delete then set up a shift and move
// M entries, one per cycle through the same RAM, and insert writes the key
// in a step of its own. The longest operation is an insert at the front of a
// table one entry short of full. The next request is taken in the cycle
// after the response register is loaded.
// A new request is taken as soon as the previous one has reached the
// response register, even while that response waits. If the response is
// still stalled when the next one is finished, the block holds in its last
// step until the response beat is taken.
// Reset empties the table at once by clearing the entry count; no sweep
// of the RAM is needed.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_delete
  import stsid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t  cmd;
  stat_t st;

  stsid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  stsid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted table with binary search, insert and delete.
// ----------------------------------------------------------------------------
// Request beats go in through a sender that works in random bursts, and a
// table model kept in step with the accepted beats predicts each response.
// A checker compares every response beat, field by field, with the oldest
// prediction. Directed tests cover the empty table, key extremes, duplicate
// keys, the unused operation code and the full table. Randomized traffic then
// drives the table up and down between empty and full. The receiver stalls on
// a pattern of its own and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import stsid_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 60;

  typedef enum int {FLOW_FREE, FLOW_RANDOM, FLOW_PATTERN} stall_mode_e;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [KEY_W-1:0] model_keys [DEPTH];
  int model_count = 0;
  rsp_t pending_outcomes [$];
  int error_count = 0;
  int hold_request = 0;
  int burst_left = 0;
  bit steady_sender = 1'b0;

  sorted_table_search_insert_delete dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int find_slot(logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = model_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] == key) return mid;
      if (model_keys[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic int first_not_below(logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = model_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one accepted request to the table model and returns its response.
  function automatic rsp_t apply_request(req_t item);
    rsp_t outcome;
    int at;
    outcome.status = ST_MISS;
    outcome.position = '0;
    case (item.operation)
      OP_SEARCH: begin
        at = find_slot(item.value);
        if (at >= 0) begin
          outcome.status = ST_OK;
          outcome.position = POS_W'(at);
        end
      end
      OP_INSERT: begin
        if (model_count >= DEPTH) begin
          outcome.status = ST_FULL;
        end else begin
          at = first_not_below(item.value);
          for (int i = model_count; i > at; i--) model_keys[i] = model_keys[i-1];
          model_keys[at] = item.value;
          model_count++;
          outcome.status = ST_OK;
          outcome.position = POS_W'(at);
        end
      end
      OP_DELETE: begin
        at = find_slot(item.value);
        if (at >= 0) begin
          for (int i = at; i < model_count - 1; i++) model_keys[i] = model_keys[i+1];
          model_count--;
          outcome.status = ST_OK;
          outcome.position = POS_W'(at);
        end
      end
      default: ;
    endcase
    outcome.entries_now = POS_W'(model_count);
    return outcome;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key(bit from_table);
    int roll;
    if (from_table && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed(KEY_W'($urandom_range(0, 16))) - 32'sd8;
    if (roll == 4) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 32'sd0;
        3: return -32'sd1;
        4: return KEY_MIN + 32'sd1;
        default: return KEY_MAX - 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic pause_sender(int cycles);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    req_t item;
    item.operation = op;
    item.value = key;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    pending_outcomes.push_back(apply_request(item));
    if (!steady_sender) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        pause_sender($urandom_range(1, 10));
      end
    end
  endtask

  task automatic wait_for_outcomes();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(OP_SEARCH, 32'sd0);
    send_request(OP_DELETE, KEY_MIN);
    send_request(OP_SPARE, KEY_MAX);
    wait_for_outcomes();
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_SEARCH, KEY_MIN);
    send_request(OP_SEARCH, KEY_MAX);
    send_request(OP_SEARCH, -32'sd1);
    send_request(OP_SEARCH, KEY_MAX - 32'sd1);
    send_request(OP_DELETE, KEY_MIN);
    send_request(OP_DELETE, KEY_MAX);
    send_request(OP_DELETE, 32'sd2);
    send_request(OP_SPARE, 32'sd1);
    wait_for_outcomes();
  endtask

  task automatic test_duplicate_keys();
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd3);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_SEARCH, 32'sd7);
    send_request(OP_DELETE, 32'sd7);
    send_request(OP_SEARCH, 32'sd7);
    wait_for_outcomes();
  endtask

  // Fills the table with random keys, then pushes inserts and other operations against the limit.
  task automatic test_full_table();
    while (model_count < DEPTH) send_request(OP_INSERT, pick_key(1'b0));
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_SEARCH, pick_key(1'b1));
    send_request(OP_SPARE, pick_key(1'b1));
    send_request(OP_DELETE, pick_key(1'b1));
    send_request(OP_INSERT, pick_key(1'b1));
    send_request(OP_INSERT, pick_key(1'b0));
    wait_for_outcomes();
  endtask

  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    steady_sender = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 0) send_request(OP_SEARCH, pick_key(1'b1));
      else send_request(OP_INSERT, pick_key(1'b0));
    end
    steady_sender = 1'b0;
    wait_for_outcomes();
  endtask

  // Phases lean toward filling, emptying or holding the table level.
  task automatic test_random_mix(int item_total);
    int ins_weight;
    int del_weight;
    int roll;
    logic [OP_W-1:0] op;
    bit from_table;
    ins_weight = 30;
    del_weight = 30;
    for (int k = 0; k < item_total; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            ins_weight = 60;
            del_weight = 15;
          end
          1: begin
            ins_weight = 15;
            del_weight = 60;
          end
          default: begin
            ins_weight = 30;
            del_weight = 30;
          end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_SPARE;
      else if (roll < 3 + ins_weight) op = OP_INSERT;
      else if (roll < 3 + ins_weight + del_weight) op = OP_DELETE;
      else op = OP_SEARCH;
      if (op == OP_INSERT) from_table = ($urandom_range(0, 4) == 0);
      else from_table = ($urandom_range(0, 2) != 0);
      send_request(op, pick_key(from_table));
      if (k % 350 == 349) wait_for_outcomes();
    end
    wait_for_outcomes();
  endtask

  initial begin
    stall_mode_e mode;
    int mode_left;
    int hold_left;
    logic [7:0] pattern;
    mode = FLOW_FREE;
    mode_left = 0;
    hold_left = 0;
    pattern = '0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
          pattern = $urandom;
        end
        mode_left--;
        case (mode)
          FLOW_FREE: rsp_stall <= 1'b0;
          FLOW_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            rsp_stall <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        $error("response beat with no request outstanding: %p", rsp);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp.position);
          error_count++;
        end
        if (rsp.entries_now !== want.entries_now) begin
          $error("entries_now: expected %0d, got %0d", want.entries_now, rsp.entries_now);
          error_count++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_key_extremes();
    test_duplicate_keys();
    test_full_table();
    test_backpressure();
    test_random_mix(1400);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
